// ----- rtl/timeout_table_manager_unit_assert.svh -----
// ----------------------------------------------------------------------------
// timeout_table_manager_unit assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef TIMEOUT_TABLE_MANAGER_UNIT_ASSERT_SVH
`define TIMEOUT_TABLE_MANAGER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttm assertion failed");

// next-cycle implication, disabled during reset
`define TTM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttm assertion failed");

`endif

// ----- rtl/ttm_pkg.sv -----
// ----------------------------------------------------------------------------
// ttm_pkg
// Constants, codes and controller/datapath types of the timeout table.
// ----------------------------------------------------------------------------
package ttm_pkg;

  localparam int SLOTS    = 4;
  localparam int SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW     = $clog2(SLOTS + 1);

  localparam int FuncW   = 2;
  localparam int IdW     = 8;
  localparam int DurW    = 15;
  localparam int RemW    = 16;
  localparam int MsW     = 8;
  localparam int StatusW = 3;

  localparam logic [MsW-1:0] MS_PER_TICK_RST = 8'd2;

  localparam logic [FuncW-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_CANCEL = 2'd1;
  localparam logic [FuncW-1:0] FUNC_TICK   = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK        = 3'd0;
  localparam logic [StatusW-1:0] STATUS_FULL      = 3'd1;
  localparam logic [StatusW-1:0] STATUS_NOT_FOUND = 3'd2;
  localparam logic [StatusW-1:0] STATUS_EXPIRED   = 3'd3;
  localparam logic [StatusW-1:0] STATUS_NONE      = 3'd4;

  // source of the data written into the slot table
  typedef enum logic [1:0] {
    WR_ITEM,
    WR_DEC,
    WR_LAST
  } wr_sel_e;

  typedef struct packed {
    logic                capture;
    logic                inc_idx;
    logic                wr_en;
    wr_sel_e             wr_sel;
    logic                wr_at_used;
    logic                inc_used;
    logic                dec_used;
    logic                set_pend;
    logic                load_out;
    logic [StatusW-1:0]  out_status;
    logic                out_from_pend;
    logic                out_last;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic hit;
    logic expire;
    logic full;
    logic out_free;
    logic pend_valid;
  } sts_t;

endpackage

// ----- rtl/ttm_if.sv -----
// ----------------------------------------------------------------------------
// ttm_in_if / ttm_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface ttm_in_if;
  logic                          valid;
  logic                          ready;
  logic [ttm_pkg::FuncW-1:0]     func;
  logic [ttm_pkg::IdW-1:0]       timer_id;
  logic [ttm_pkg::DurW-1:0]      duration_ms;

  modport source (output valid, func, timer_id, duration_ms, input ready);
  modport sink   (input valid, func, timer_id, duration_ms, output ready);
endinterface

interface ttm_out_if;
  logic                          valid;
  logic                          ready;
  logic [ttm_pkg::StatusW-1:0]   status;
  logic [ttm_pkg::IdW-1:0]       expired_id;
  logic                          last;

  modport source (output valid, status, expired_id, last, input ready);
  modport sink   (input valid, status, expired_id, last, output ready);
endinterface

// ----- rtl/timeout_table_manager_unit.sv -----
// ----------------------------------------------------------------------------
// timeout_table_manager_unit
// Table of pending timeouts: add/rearm, cancel, and tick with expiry report.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  in_if     in    valid/ready          func, timer_id, duration_ms
//  out_if    out   valid/ready          status, expired_id, last
//  cfg       in    cfg_we_i (no ready)  cfg_wdata_i = ms_per_tick
//
// Each table entry visited is read in a read state and then evaluated in an
// evaluate state, since the slot memory has registered reads. An add or cancel
// walks until a hit or the end of the table; a tick visits every used entry.
// A new item is taken as soon as the final result sits in the output register.
// Reset empties the table and sets ms_per_tick to 2; no clearing pass.
// A full output register holds the walk where a result must be loaded, until it drains.
// ----------------------------------------------------------------------------
module timeout_table_manager_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ttm_pkg::MsW-1:0] cfg_wdata_i,
  ttm_in_if.sink                  in_if,
  ttm_out_if.source               out_if
);

  ttm_pkg::cmd_t cmd;
  ttm_pkg::sts_t sts;

  ttm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_func_i  (in_if.func),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ttm_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_timer_id_i    (in_if.timer_id),
    .in_duration_ms_i (in_if.duration_ms),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_if.ready),
    .out_valid_o      (out_if.valid),
    .out_status_o     (out_if.status),
    .out_expired_id_o (out_if.expired_id),
    .out_last_o       (out_if.last)
  );

endmodule

// ----- rtl/ttm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttm_ctrl
// Sequencer: walks the slot table one entry per read/evaluate pair.
// ----------------------------------------------------------------------------
module ttm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [ttm_pkg::FuncW-1:0] in_func_i,
  output logic                      in_ready_o,
  input  ttm_pkg::sts_t             sts_i,
  output ttm_pkg::cmd_t             cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD_RD = 3'd1;
  localparam logic [2:0] S_ADD_EV = 3'd2;
  localparam logic [2:0] S_CAN_RD = 3'd3;
  localparam logic [2:0] S_CAN_EV = 3'd4;
  localparam logic [2:0] S_TCK_RD = 3'd5;
  localparam logic [2:0] S_TCK_EV = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.wr_sel = ttm_pkg::WR_ITEM;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_func_i)
            ttm_pkg::FUNC_ADD: begin
              cmd_o.capture = 1'b1;
              state_d = S_ADD_RD;
            end
            ttm_pkg::FUNC_CANCEL: begin
              cmd_o.capture = 1'b1;
              state_d = S_CAN_RD;
            end
            ttm_pkg::FUNC_TICK: begin
              cmd_o.capture = 1'b1;
              state_d = S_TCK_RD;
            end
            default: ;  // unused code: item dropped
          endcase
        end
      end
      S_ADD_RD: state_d = S_ADD_EV;
      S_CAN_RD: state_d = S_CAN_EV;
      S_TCK_RD: state_d = S_TCK_EV;
      S_ADD_EV: begin
        if (sts_i.hit) begin
          if (sts_i.out_free) begin
            cmd_o.wr_en      = 1'b1;
            cmd_o.load_out   = 1'b1;
            cmd_o.out_status = ttm_pkg::STATUS_OK;
            cmd_o.out_last   = 1'b1;
            state_d = S_IDLE;
          end
        end else if (sts_i.at_end) begin
          if (sts_i.out_free) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_last = 1'b1;
            if (sts_i.full) begin
              cmd_o.out_status = ttm_pkg::STATUS_FULL;
            end else begin
              cmd_o.out_status = ttm_pkg::STATUS_OK;
              cmd_o.wr_en      = 1'b1;
              cmd_o.wr_at_used = 1'b1;
              cmd_o.inc_used   = 1'b1;
            end
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d = S_ADD_RD;
        end
      end
      S_CAN_EV: begin
        if (sts_i.hit) begin
          if (sts_i.out_free) begin
            cmd_o.wr_en      = 1'b1;
            cmd_o.wr_sel     = ttm_pkg::WR_LAST;
            cmd_o.dec_used   = 1'b1;
            cmd_o.load_out   = 1'b1;
            cmd_o.out_status = ttm_pkg::STATUS_OK;
            cmd_o.out_last   = 1'b1;
            state_d = S_IDLE;
          end
        end else if (sts_i.at_end) begin
          if (sts_i.out_free) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.out_status = ttm_pkg::STATUS_NOT_FOUND;
            cmd_o.out_last   = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d = S_CAN_RD;
        end
      end
      S_TCK_EV: begin
        if (sts_i.at_end) begin
          // flush the held expiry as the final result, or report none
          if (sts_i.out_free) begin
            cmd_o.load_out      = 1'b1;
            cmd_o.out_status    = sts_i.pend_valid ? ttm_pkg::STATUS_EXPIRED
                                                   : ttm_pkg::STATUS_NONE;
            cmd_o.out_from_pend = sts_i.pend_valid;
            cmd_o.out_last      = 1'b1;
            state_d = S_IDLE;
          end
        end else if (sts_i.expire) begin
          // one expiry is held back so the last one can be flagged
          if (!sts_i.pend_valid || sts_i.out_free) begin
            cmd_o.load_out      = sts_i.pend_valid;
            cmd_o.out_status    = ttm_pkg::STATUS_EXPIRED;
            cmd_o.out_from_pend = 1'b1;
            cmd_o.wr_en         = 1'b1;
            cmd_o.wr_sel        = ttm_pkg::WR_LAST;
            cmd_o.dec_used      = 1'b1;
            cmd_o.set_pend      = 1'b1;
            state_d = S_TCK_RD;
          end
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = ttm_pkg::WR_DEC;
          cmd_o.inc_idx = 1'b1;
          state_d = S_TCK_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/ttm_dpath.sv -----
// ----------------------------------------------------------------------------
// ttm_dpath
// Slot table memory, walk index, held expiry and result register.
// ----------------------------------------------------------------------------
module ttm_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ttm_pkg::MsW-1:0]     cfg_wdata_i,
  input  logic [ttm_pkg::IdW-1:0]     in_timer_id_i,
  input  logic [ttm_pkg::DurW-1:0]    in_duration_ms_i,
  input  ttm_pkg::cmd_t               cmd_i,
  output ttm_pkg::sts_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [ttm_pkg::StatusW-1:0] out_status_o,
  output logic [ttm_pkg::IdW-1:0]     out_expired_id_o,
  output logic                        out_last_o
);

  logic [ttm_pkg::IdW-1:0]          id_mem  [ttm_pkg::SLOTS];
  logic [ttm_pkg::RemW-1:0]         rem_mem [ttm_pkg::SLOTS];

  logic [ttm_pkg::MsW-1:0]          ms_q;
  logic [ttm_pkg::CntW-1:0]         used_q, idx_q;
  logic                             pend_valid_q;
  logic [ttm_pkg::IdW-1:0]          pend_id_q;
  logic [ttm_pkg::IdW-1:0]          id_q;
  logic [ttm_pkg::DurW-1:0]         dur_q;
  logic [ttm_pkg::IdW-1:0]          rd0_id_q, rd1_id_q;
  logic [ttm_pkg::RemW-1:0]         rd0_rem_q, rd1_rem_q;
  logic                             out_valid_q;
  logic [ttm_pkg::StatusW-1:0]      out_status_q;
  logic [ttm_pkg::IdW-1:0]          out_id_q;
  logic                             out_last_q;

  logic [ttm_pkg::CntW-1:0]         last_cnt;
  logic [ttm_pkg::SlotIdxW-1:0]     waddr;
  logic [ttm_pkg::IdW-1:0]          wid;
  logic [ttm_pkg::RemW-1:0]         wrem;
  logic signed [ttm_pkg::RemW:0]    diff;

  assign last_cnt = used_q - ttm_pkg::CntW'(1);
  assign diff = $signed({rd0_rem_q[ttm_pkg::RemW-1], rd0_rem_q})
              - $signed({(ttm_pkg::RemW + 1 - ttm_pkg::MsW)'(0), ms_q});

  assign waddr = cmd_i.wr_at_used ? used_q[ttm_pkg::SlotIdxW-1:0]
                                  : idx_q[ttm_pkg::SlotIdxW-1:0];

  always_comb begin
    case (cmd_i.wr_sel)
      ttm_pkg::WR_DEC: begin
        wid  = rd0_id_q;
        wrem = diff[ttm_pkg::RemW-1:0];
      end
      ttm_pkg::WR_LAST: begin
        wid  = rd1_id_q;
        wrem = rd1_rem_q;
      end
      default: begin
        wid  = id_q;
        wrem = {1'b0, dur_q};
      end
    endcase
  end

  // table: one write port, reads at the walk index and at the last used slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      id_mem[waddr]  <= wid;
      rem_mem[waddr] <= wrem;
    end
    rd0_id_q  <= id_mem[idx_q[ttm_pkg::SlotIdxW-1:0]];
    rd0_rem_q <= rem_mem[idx_q[ttm_pkg::SlotIdxW-1:0]];
    rd1_id_q  <= id_mem[last_cnt[ttm_pkg::SlotIdxW-1:0]];
    rd1_rem_q <= rem_mem[last_cnt[ttm_pkg::SlotIdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q         <= ttm_pkg::MS_PER_TICK_RST;
      used_q       <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ms_q <= cfg_wdata_i;
      end
      if (cmd_i.inc_used) begin
        used_q <= used_q + ttm_pkg::CntW'(1);
      end else if (cmd_i.dec_used) begin
        used_q <= last_cnt;
      end
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + ttm_pkg::CntW'(1);
      end
      if (cmd_i.capture) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.set_pend) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q  <= in_timer_id_i;
      dur_q <= in_duration_ms_i;
    end
    if (cmd_i.set_pend) begin
      pend_id_q <= rd0_id_q;
    end
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.out_status;
      out_id_q     <= cmd_i.out_from_pend ? pend_id_q : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  always_comb begin
    sts_o.at_end     = (idx_q >= used_q);
    sts_o.hit        = (idx_q < used_q) && (rd0_id_q == id_q);
    sts_o.expire     = diff[ttm_pkg::RemW] || (diff == '0);
    sts_o.full       = (used_q == ttm_pkg::CntW'(ttm_pkg::SLOTS));
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.pend_valid = pend_valid_q;
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_expired_id_o = out_id_q;
  assign out_last_o       = out_last_q;

endmodule

// ----- rtl/ttm_checker.sv -----
// ----------------------------------------------------------------------------
// ttm_checker
// Port-level checks of the timeout table, bound to the top level.
// ----------------------------------------------------------------------------
`include "timeout_table_manager_unit_assert.svh"

module ttm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ttm_pkg::StatusW-1:0] out_status_i,
  input logic [ttm_pkg::IdW-1:0]     out_expired_id_i,
  input logic                        out_last_i
);

  `TTM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  `TTM_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_status_i) && $stable(out_expired_id_i) && $stable(out_last_i))

  // only expiries come as non-final results, and only they carry an id
  `TTM_ASSERT_IMP(a_non_expiry_last, clk_i, rst_ni, out_valid_i && (out_status_i != ttm_pkg::STATUS_EXPIRED), out_last_i && (out_expired_id_i == '0))

  // a tick still has results to give while a non-final one waits
  `TTM_ASSERT_IMP(a_busy_mid_tick, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i)

endmodule

bind timeout_table_manager_unit ttm_checker u_ttm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .out_status_i     (out_if.status),
  .out_expired_id_i (out_if.expired_id),
  .out_last_i       (out_if.last)
);

// ----- test/timeout_table_manager_unit_tb.sv -----
// ----------------------------------------------------------------------------
// timeout_table_manager_unit_tb
// Self-checking bench for the timeout table: add, rearm, cancel, reserved and
// tick commands. Each result is compared against a behavioral table model.
// The tick length is changed between phases while the block is idle. The
// command side sends in random bursts and the result side stalls on a
// rotating ready pattern.
// ----------------------------------------------------------------------------
module timeout_table_manager_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ttm_pkg::FuncW-1:0] FUNC_RSVD = 2'd3;  // ignored by the block
  localparam int DRAIN_CYCLES = 2 * ttm_pkg::SLOTS + 2 + 12;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 55;
  localparam int POOL_SIZE    = 6;

  typedef struct packed {
    logic [ttm_pkg::StatusW-1:0] status;
    logic [ttm_pkg::IdW-1:0]     expired_id;
    logic                        last;
  } result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [ttm_pkg::MsW-1:0]   cfg_wdata_i;

  ttm_in_if  in_if ();
  ttm_out_if out_if ();

  timeout_table_manager_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // table model
  logic [ttm_pkg::IdW-1:0]         tbl_id [ttm_pkg::SLOTS];
  logic signed [ttm_pkg::RemW-1:0] tbl_rem [ttm_pkg::SLOTS];
  int unsigned                     tbl_used;
  logic [ttm_pkg::MsW-1:0]         tick_ms;

  result_t                         pending_results[$];
  int                              errors;
  int                              burst_left;
  logic [ttm_pkg::IdW-1:0]         id_pool [POOL_SIZE];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void push_result(logic [ttm_pkg::StatusW-1:0] st,
                                      logic [ttm_pkg::IdW-1:0] id, logic lst);
    result_t r;
    r.status     = st;
    r.expired_id = id;
    r.last       = lst;
    pending_results.push_back(r);
  endfunction

  function automatic int find_entry(logic [ttm_pkg::IdW-1:0] id);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // compaction: the last used entry fills the vacated slot
  function automatic void drop_entry(int idx);
    int lst;
    lst = tbl_used - 1;
    if (idx != lst) begin
      tbl_id[idx]  = tbl_id[lst];
      tbl_rem[idx] = tbl_rem[lst];
    end
    tbl_used = lst;
  endfunction

  function automatic void predict_results(logic [ttm_pkg::FuncW-1:0] f,
                                          logic [ttm_pkg::IdW-1:0] id,
                                          logic [ttm_pkg::DurW-1:0] dur);
    int s;
    int i;
    int v;
    int n;
    case (f)
      ttm_pkg::FUNC_ADD: begin
        s = find_entry(id);
        if (s >= 0) begin
          tbl_rem[s] = $signed({1'b0, dur});
          push_result(ttm_pkg::STATUS_OK, '0, 1'b1);
        end else if (tbl_used < ttm_pkg::SLOTS) begin
          tbl_id[tbl_used]  = id;
          tbl_rem[tbl_used] = $signed({1'b0, dur});
          tbl_used++;
          push_result(ttm_pkg::STATUS_OK, '0, 1'b1);
        end else begin
          push_result(ttm_pkg::STATUS_FULL, '0, 1'b1);
        end
      end
      ttm_pkg::FUNC_CANCEL: begin
        s = find_entry(id);
        if (s < 0) begin
          push_result(ttm_pkg::STATUS_NOT_FOUND, '0, 1'b1);
        end else begin
          drop_entry(s);
          push_result(ttm_pkg::STATUS_OK, '0, 1'b1);
        end
      end
      ttm_pkg::FUNC_TICK: begin
        i = 0;
        n = 0;
        while (i < tbl_used) begin
          v = int'(tbl_rem[i]) - int'(tick_ms);
          if (v < -32768) v = -32768;
          tbl_rem[i] = ttm_pkg::RemW'(v);
          if (v <= 0) begin
            push_result(ttm_pkg::STATUS_EXPIRED, tbl_id[i], 1'b0);
            drop_entry(i);
            n++;
          end else begin
            i++;
          end
        end
        if (n == 0) push_result(ttm_pkg::STATUS_NONE, '0, 1'b1);
        else pending_results[pending_results.size() - 1].last = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // Leaves valid high when no gap follows, so a send right after reuses it.
  task automatic send_cmd(input logic [ttm_pkg::FuncW-1:0] f,
                          input logic [ttm_pkg::IdW-1:0] id,
                          input logic [ttm_pkg::DurW-1:0] dur);
    int gap;
    in_if.valid       <= 1'b1;
    in_if.func        <= f;
    in_if.timer_id    <= id;
    in_if.duration_ms <= dur;
    @(posedge clk_i);
    while (!(in_if.valid && in_if.ready)) @(posedge clk_i);
    predict_results(f, id, dur);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_tick_ms(input logic [ttm_pkg::MsW-1:0] ms);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ms;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tick_ms = ms;
  endtask

  function automatic logic [ttm_pkg::DurW-1:0] pick_duration();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return ttm_pkg::DurW'($urandom_range(0, 4 * int'(tick_ms) + 2));
    if (sel < 8) return ttm_pkg::DurW'($urandom_range(0, 1000));
    return ttm_pkg::DurW'($urandom());
  endfunction

  task automatic test_directed_ops();
    send_cmd(ttm_pkg::FUNC_TICK, 8'h00, 15'h0000);       // empty table
    send_cmd(ttm_pkg::FUNC_ADD, 8'h00, 15'h0000);        // zero duration
    send_cmd(ttm_pkg::FUNC_ADD, 8'hFF, 15'h7FFF);
    send_cmd(ttm_pkg::FUNC_ADD, 8'h5A, 15'd3);
    send_cmd(ttm_pkg::FUNC_ADD, 8'hA5, 15'h2AAA);
    send_cmd(ttm_pkg::FUNC_ADD, 8'h33, 15'd5);           // table full
    send_cmd(ttm_pkg::FUNC_ADD, 8'h5A, 15'd1);           // rearm in place
    send_cmd(ttm_pkg::FUNC_CANCEL, 8'h77, 15'h5555);     // absent id
    send_cmd(FUNC_RSVD, 8'h33, 15'h5555);
    send_cmd(ttm_pkg::FUNC_TICK, 8'hFF, 15'h7FFF);
    send_cmd(ttm_pkg::FUNC_CANCEL, 8'hFF, 15'h0000);
    send_cmd(ttm_pkg::FUNC_CANCEL, 8'hA5, 15'h0000);
    send_cmd(ttm_pkg::FUNC_CANCEL, 8'hA5, 15'h0000);
    send_cmd(ttm_pkg::FUNC_TICK, 8'h00, 15'h0000);
    for (int k = 1; k <= ttm_pkg::SLOTS; k++) begin
      send_cmd(ttm_pkg::FUNC_ADD, ttm_pkg::IdW'(k), 15'd2);
    end
    send_cmd(ttm_pkg::FUNC_TICK, 8'h00, 15'h0000);       // every slot expires
    send_cmd(ttm_pkg::FUNC_ADD, 8'd10, 15'd1);
    send_cmd(ttm_pkg::FUNC_ADD, 8'd20, 15'd9);
    send_cmd(ttm_pkg::FUNC_ADD, 8'd30, 15'd1);
    send_cmd(ttm_pkg::FUNC_CANCEL, 8'd10, 15'h0000);     // 30 moves into slot 0
    send_cmd(ttm_pkg::FUNC_TICK, 8'h00, 15'h0000);
  endtask

  task automatic test_tick_config();
    set_tick_ms(8'd0);
    send_cmd(ttm_pkg::FUNC_ADD, 8'h11, 15'd0);
    send_cmd(ttm_pkg::FUNC_ADD, 8'h22, 15'd9);
    send_cmd(ttm_pkg::FUNC_TICK, 8'h00, 15'h0000);       // only the zero entry goes
    send_cmd(ttm_pkg::FUNC_TICK, 8'h00, 15'h0000);
    set_tick_ms(8'd255);
    send_cmd(ttm_pkg::FUNC_ADD, 8'h44, 15'd255);
    send_cmd(ttm_pkg::FUNC_ADD, 8'h55, 15'd256);
    send_cmd(ttm_pkg::FUNC_TICK, 8'h00, 15'h0000);
    set_tick_ms(8'd1);
    send_cmd(ttm_pkg::FUNC_TICK, 8'h00, 15'h0000);
  endtask

  task automatic test_random_traffic(input logic [ttm_pkg::MsW-1:0] ms);
    int pick;
    set_tick_ms(ms);
    for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = ttm_pkg::IdW'($urandom());
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_cmd(ttm_pkg::FUNC_ADD, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                 pick_duration());
      else if (pick < 40)
        send_cmd(ttm_pkg::FUNC_ADD, ttm_pkg::IdW'($urandom()),
                 ttm_pkg::DurW'($urandom()));
      else if (pick < 58)
        send_cmd(ttm_pkg::FUNC_CANCEL, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                 ttm_pkg::DurW'($urandom()));
      else if (pick < 63)
        send_cmd(ttm_pkg::FUNC_CANCEL, ttm_pkg::IdW'($urandom()),
                 ttm_pkg::DurW'($urandom()));
      else if (pick < 95)
        send_cmd(ttm_pkg::FUNC_TICK, ttm_pkg::IdW'($urandom()),
                 ttm_pkg::DurW'($urandom()));
      else
        send_cmd(FUNC_RSVD, ttm_pkg::IdW'($urandom()), ttm_pkg::DurW'($urandom()));
    end
  endtask

  // result-side ready: a rotating pattern, reloaded now and then
  logic [15:0] rdy_pat = 16'hFFFF;
  int          pat_age = 0;

  always @(posedge clk_i) begin
    if (pat_age == 0) begin
      if ($urandom_range(0, 3) == 0) rdy_pat <= 16'hFFFF;
      else if ($urandom_range(0, 1) == 0) rdy_pat <= 16'($urandom()) | 16'h0001;
      else rdy_pat <= 16'($urandom() & $urandom()) | 16'h0001;
      pat_age <= $urandom_range(32, 160);
    end else begin
      rdy_pat <= {rdy_pat[0], rdy_pat[15:1]};
      pat_age <= pat_age - 1;
    end
    out_if.ready <= rdy_pat[0];
  end

  always @(posedge clk_i) begin : chk_results
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, expired_id %0d, last %0d",
               out_if.status, out_if.expired_id, out_if.last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_if.status);
          errors++;
        end
        if (out_if.expired_id !== want.expired_id) begin
          $error("expired_id mismatch: expected %0d, actual %0d",
                 want.expired_id, out_if.expired_id);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_if.last);
          errors++;
        end
      end
    end
  end

  // no progress on either channel for too long ends the run
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    errors     = 0;
    burst_left = 8;
    tbl_used   = 0;
    tick_ms    = ttm_pkg::MS_PER_TICK_RST;
    for (int k = 0; k < ttm_pkg::SLOTS; k++) begin
      tbl_id[k]  = '0;
      tbl_rem[k] = '0;
    end
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_if.valid       <= 1'b0;
    in_if.func        <= ttm_pkg::FUNC_ADD;
    in_if.timer_id    <= '0;
    in_if.duration_ms <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_tick_config();
    test_random_traffic(8'd1);
    test_random_traffic(8'd255);
    test_random_traffic(8'd0);
    test_random_traffic(ttm_pkg::MsW'($urandom_range(3, 40)));
    test_random_traffic(ttm_pkg::MsW'($urandom()));
    test_random_traffic(ttm_pkg::MS_PER_TICK_RST);

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
